>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// holds operation codes, controller states and command/status structs
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

  localparam int unsigned NumOutBits = 33;
  localparam int unsigned DenOutBits = 31;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StLoadA,
    StGcdA,
    StDivA,
    StLoadB,
    StGcdB,
    StDivB,
    StMul,
    StComb,
    StLoadR,
    StGcdR,
    StDivR,
    StOut
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic load_a;
    logic load_b;
    logic load_r;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic save_a;
    logic save_b;
    logic mul;
    logic comb;
    logic save_r;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if: valid/ready channel carrying a payload
// generic handshake channel with source and sink views
// ----------------------------------------------------------------------------
`default_nettype none
interface rau_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing controller
// steps through operand reduction, cross products and result reduction
// ----------------------------------------------------------------------------
`default_nettype none
module rau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rau_pkg::stat_t stat_i,
  output rau_pkg::cmd_t      cmd_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StLoadA;
        end
      end
      StLoadA: begin
        cmd_o.load_a = 1'b1;
        state_d = StGcdA;
      end
      StGcdA: begin
        cmd_o.gcd_step = 1'b1;
        if (stat_i.gcd_done) begin
          cmd_o.gcd_step  = 1'b0;
          cmd_o.div_start = 1'b1;
          state_d = StDivA;
        end
      end
      StDivA: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.div_step = 1'b0;
          cmd_o.save_a   = 1'b1;
          state_d = StLoadB;
        end
      end
      StLoadB: begin
        cmd_o.load_b = 1'b1;
        state_d = StGcdB;
      end
      StGcdB: begin
        cmd_o.gcd_step = 1'b1;
        if (stat_i.gcd_done) begin
          cmd_o.gcd_step  = 1'b0;
          cmd_o.div_start = 1'b1;
          state_d = StDivB;
        end
      end
      StDivB: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.div_step = 1'b0;
          cmd_o.save_b   = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StComb;
      end
      StComb: begin
        cmd_o.comb = 1'b1;
        state_d = StLoadR;
      end
      StLoadR: begin
        cmd_o.load_r = 1'b1;
        state_d = StGcdR;
      end
      StGcdR: begin
        cmd_o.gcd_step = 1'b1;
        if (stat_i.gcd_done) begin
          cmd_o.gcd_step  = 1'b0;
          cmd_o.div_start = 1'b1;
          state_d = StDivR;
        end
      end
      StDivR: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.div_step = 1'b0;
          cmd_o.save_r   = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_ready_i) |=> state_q == StOut)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StLoadA)
    else $error("accepted request not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.gcd_step, cmd_o.div_step, cmd_o.div_start}))
    else $error("gcd and divider commanded together");

endmodule
`default_nettype wire

>>> rtl/core/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: datapath
// one-bit-per-cycle remainder unit for euclid, restoring divider for the
// quotients, registered multiplier and sign-magnitude adder
// ----------------------------------------------------------------------------
`default_nettype none
module rau_dp #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rau_pkg::cmd_t                   cmd_i,
  output rau_pkg::stat_t                       stat_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic signed [OPERAND_BITS-1:0]  a_num_i,
  input  wire logic signed [OPERAND_BITS-1:0]  a_den_i,
  input  wire logic signed [OPERAND_BITS-1:0]  b_num_i,
  input  wire logic signed [OPERAND_BITS-1:0]  b_den_i,
  output logic signed [rau_pkg::NumOutBits-1:0] res_num_o,
  output logic [rau_pkg::DenOutBits-1:0]        res_den_o
);
  import rau_pkg::*;

  localparam int unsigned Mb = OPERAND_BITS;      // operand magnitude bits
  localparam int unsigned W  = 2 * Mb + 1;        // widest intermediate
  localparam int unsigned PW = 2 * Mb;            // product width
  localparam int unsigned CW = $clog2(W + 1);

  logic [1:0]   mode_q;
  logic [Mb-1:0] an_q, ad_q, bn_q, bd_q;   // raw inputs
  logic          ans_q, ads_q, bns_q, bds_q;

  // reduced operands
  logic          sa_q, sb_q;
  logic [Mb-1:0] ra_n_q, ra_d_q, rb_n_q, rb_d_q;

  // products
  logic [W-1:0]  p1_q, p2_q, pd_q;
  logic          nneg_q, dneg_q;

  // gcd working pair and the values being reduced
  logic [W-1:0]  x_q, y_q, r_q, nv_q, dv_q;
  logic          gneg_q;
  logic [CW-1:0] cnt_q;
  logic          rem_busy_q;

  // divider state: divides nv by g and dv by g in parallel
  logic [W-1:0]  qn_q, qd_q, rn_q, rd_q, g_q;

  function automatic logic [Mb-1:0] mag(input logic [Mb-1:0] v);
    return v[Mb-1] ? (~v + 1'b1) : v;
  endfunction

  logic          ld_neg;
  logic [W-1:0]  ld_n, ld_d;
  always_comb begin
    ld_neg = 1'b0;
    ld_n   = '0;
    ld_d   = '0;
    if (cmd_i.load_a) begin
      ld_n   = W'(mag(an_q));
      ld_d   = (ad_q == '0) ? W'(1) : W'(mag(ad_q));
      ld_neg = ans_q ^ ((ad_q != '0) && ads_q);
    end else if (cmd_i.load_b) begin
      ld_n   = W'(mag(bn_q));
      ld_d   = (bd_q == '0) ? W'(1) : W'(mag(bd_q));
      ld_neg = bns_q ^ ((bd_q != '0) && bds_q);
    end else begin
      ld_n   = p1_q;
      ld_d   = (pd_q == '0) ? W'(1) : pd_q;
      ld_neg = nneg_q ^ ((pd_q != '0) && dneg_q);
    end
  end

  // one bit of x mod y per cycle
  logic [W:0] rem_try;
  assign rem_try = {r_q, x_q[W-1]} - {1'b0, y_q};

  assign stat_o.gcd_done = !rem_busy_q && (y_q == '0);
  assign stat_o.div_done = (cnt_q == '0);

  logic [W:0] qn_try, qd_try;
  assign qn_try = {rn_q, nv_q[W-1]} - {1'b0, g_q};
  assign qd_try = {rd_q, dv_q[W-1]} - {1'b0, g_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rem_busy_q <= 1'b0;
    end else begin
      if (cmd_i.load_a || cmd_i.load_b || cmd_i.load_r) begin
        rem_busy_q <= 1'b0;
        cnt_q      <= '0;
      end else if (cmd_i.gcd_step) begin
        if (!rem_busy_q) begin
          rem_busy_q <= 1'b1;
          cnt_q      <= CW'(W);
        end else if (cnt_q == CW'(1)) begin
          rem_busy_q <= 1'b0;
          cnt_q      <= '0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else if (cmd_i.div_start) begin
        cnt_q <= CW'(W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      an_q <= a_num_i; ad_q <= a_den_i; bn_q <= b_num_i; bd_q <= b_den_i;
      ans_q <= a_num_i[Mb-1]; ads_q <= a_den_i[Mb-1];
      bns_q <= b_num_i[Mb-1]; bds_q <= b_den_i[Mb-1];
    end
    if (cmd_i.load_a || cmd_i.load_b || cmd_i.load_r) begin
      nv_q <= ld_n; dv_q <= ld_d; gneg_q <= ld_neg;
      x_q  <= ld_n; y_q  <= ld_d; r_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!rem_busy_q) begin
        r_q <= '0;
      end else begin
        // shift x through r, keeping remainder
        if (!rem_try[W]) begin
          r_q <= rem_try[W-1:0];
        end else begin
          r_q <= {r_q[W-2:0], x_q[W-1]};
        end
        if (cnt_q == CW'(1)) begin
          x_q <= y_q;
          y_q <= !rem_try[W] ? rem_try[W-1:0] : {r_q[W-2:0], x_q[W-1]};
        end else begin
          x_q <= {x_q[W-2:0], 1'b0};
        end
      end
    end else if (cmd_i.div_start) begin
      g_q <= x_q; rn_q <= '0; rd_q <= '0; qn_q <= '0; qd_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q <= qn_try[W] ? {rn_q[W-2:0], nv_q[W-1]} : qn_try[W-1:0];
      rd_q <= qd_try[W] ? {rd_q[W-2:0], dv_q[W-1]} : qd_try[W-1:0];
      qn_q <= {qn_q[W-2:0], !qn_try[W]};
      qd_q <= {qd_q[W-2:0], !qd_try[W]};
      nv_q <= {nv_q[W-2:0], 1'b0};
      dv_q <= {dv_q[W-2:0], 1'b0};
    end
    if (cmd_i.save_a) begin
      ra_n_q <= qn_q[Mb-1:0]; ra_d_q <= qd_q[Mb-1:0];
      sa_q <= gneg_q && (qn_q != '0);
    end
    if (cmd_i.save_b) begin
      rb_n_q <= qn_q[Mb-1:0]; rb_d_q <= qd_q[Mb-1:0];
      sb_q <= gneg_q && (qn_q != '0);
    end
    if (cmd_i.mul) begin
      case (op_e'(mode_q))
        OpMul: begin
          p1_q <= W'(PW'(ra_n_q) * PW'(rb_n_q)); p2_q <= '0;
          pd_q <= W'(PW'(ra_d_q) * PW'(rb_d_q));
        end
        OpDiv: begin
          p1_q <= W'(PW'(ra_n_q) * PW'(rb_d_q)); p2_q <= '0;
          pd_q <= W'(PW'(ra_d_q) * PW'(rb_n_q));
        end
        default: begin
          p1_q <= W'(PW'(ra_n_q) * PW'(rb_d_q));
          p2_q <= W'(PW'(rb_n_q) * PW'(ra_d_q));
          pd_q <= W'(PW'(ra_d_q) * PW'(rb_d_q));
        end
      endcase
    end
    if (cmd_i.comb) begin
      case (op_e'(mode_q))
        OpMul: begin
          nneg_q <= sa_q ^ sb_q; dneg_q <= 1'b0;
        end
        OpDiv: begin
          nneg_q <= sa_q; dneg_q <= sb_q;
        end
        default: begin
          dneg_q <= 1'b0;
          if (sa_q == (sb_q ^ (mode_q == OpSub))) begin
            nneg_q <= sa_q; p1_q <= p1_q + p2_q;
          end else if (p1_q >= p2_q) begin
            nneg_q <= sa_q; p1_q <= p1_q - p2_q;
          end else begin
            nneg_q <= sb_q ^ (mode_q == OpSub); p1_q <= p2_q - p1_q;
          end
        end
      endcase
    end
    if (cmd_i.save_r) begin
      res_num_o <= (gneg_q && (qn_q != '0)) ? NumOutBits'(~qn_q + 1'b1)
                                            : NumOutBits'(qn_q);
      res_den_o <= DenOutBits'(qd_q);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit.sv
// sequence: three reductions, each a load step, repeated euclid remainder passes
// (W = 2*OPERAND_BITS+1 bits wide), a done step and a quotient pass, plus
// capture, products, combine and output steps
// throughput: one request at a time, set by the shared bit-serial remainder unit
// reset: asynchronous active low, controller returns to idle, payload not cleared
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div in lowest terms
// reduces both operands by euclid, forms cross products, reduces the result
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rau_if.sink      in_if,
  rau_if.source    out_if
);
  import rau_pkg::*;

  cmd_t  cmd;     // controller commands
  stat_t stat;    // datapath status

  // controller: sequences operand and result reduction
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: gcd, quotient, product and sum hardware
  rau_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .mode_i    (in_if.data.mode),
    .a_num_i   (in_if.data.a_num),
    .a_den_i   (in_if.data.a_den),
    .b_num_i   (in_if.data.b_num),
    .b_den_i   (in_if.data.b_den),
    .res_num_o (out_if.data.res_num),
    .res_den_o (out_if.data.res_den)
  );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rational arithmetic unit
// drives fraction requests with random gaps, predicts the reduced result of
// each accepted request and compares it with the returned fraction in order
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import rau_pkg::*;

  localparam int unsigned OB = 16;

  // request and result payloads as carried by the channels
  typedef struct packed {
    op_e             mode;
    logic [OB-1:0]   a_num;
    logic [OB-1:0]   a_den;
    logic [OB-1:0]   b_num;
    logic [OB-1:0]   b_den;
  } frac_req_t;

  typedef struct packed {
    logic [NumOutBits-1:0] res_num;
    logic [DenOutBits-1:0] res_den;
  } frac_res_t;

  // scoreboard: predicts the reduced fraction and checks returned results
  class fraction_board;
    frac_res_t expected_q[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // zero denominator becomes one, divide by gcd, sign onto the numerator
    static function void lowest_terms(input bit nneg, input longint unsigned nmag,
                                      input bit dneg, input longint unsigned dmag,
                                      output bit neg, output longint unsigned nm,
                                      output longint unsigned dm);
      longint unsigned g;
      if (dmag == 0) begin
        dmag = 1;
        dneg = 1'b0;
      end
      g = euclid(nmag, dmag);
      nm = nmag / g;
      dm = dmag / g;
      neg = (nm != 0) && (nneg != dneg);
    endfunction

    static function void operand(input logic [OB-1:0] n, input logic [OB-1:0] d,
                                 output bit neg, output longint unsigned nm,
                                 output longint unsigned dm);
      bit nn, dn;
      longint unsigned nmag, dmag;
      nn = n[OB-1];
      dn = d[OB-1];
      nmag = nn ? ((64'd1 << OB) - n) : n;
      dmag = dn ? ((64'd1 << OB) - d) : d;
      lowest_terms(nn, nmag, dn, dmag, neg, nm, dm);
    endfunction

    static function frac_res_t predict(frac_req_t rq);
      bit an, bn, s2, nneg, dneg, rn;
      longint unsigned anm, adm, bnm, bdm, t1, t2, nmag, dmag, rnm, rdm, bits;
      frac_res_t rs;
      operand(rq.a_num, rq.a_den, an, anm, adm);
      operand(rq.b_num, rq.b_den, bn, bnm, bdm);
      dneg = 1'b0;
      case (rq.mode)
        OpAdd, OpSub: begin
          s2 = (rq.mode == OpSub) ? !bn : bn;
          t1 = anm * bdm;
          t2 = bnm * adm;
          if (an == s2) begin
            nneg = an;
            nmag = t1 + t2;
          end else if (t1 >= t2) begin
            nneg = an;
            nmag = t1 - t2;
          end else begin
            nneg = s2;
            nmag = t2 - t1;
          end
          dmag = adm * bdm;
        end
        OpMul: begin
          nneg = an != bn;
          nmag = anm * bnm;
          dmag = adm * bdm;
        end
        default: begin
          nneg = an;
          nmag = anm * bdm;
          dneg = bn;
          dmag = adm * bnm;
        end
      endcase
      lowest_terms(nneg, nmag, dneg, dmag, rn, rnm, rdm);
      bits = rn ? (64'd0 - rnm) : rnm;
      rs.res_num = bits[NumOutBits-1:0];
      rs.res_den = rdm[DenOutBits-1:0];
      return rs;
    endfunction

    function void note_request(frac_req_t rq);
      expected_q.push_back(predict(rq));
    endfunction

    function void check_result(frac_res_t got);
      frac_res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result num=%0d den=%0d", $signed(got.res_num), got.res_den);
        return;
      end
      want = expected_q.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d/%0d got %0d/%0d", $signed(want.res_num),
                   want.res_den, $signed(got.res_num), got.res_den);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rau_if #(.T(frac_req_t)) req_ch ();
  rau_if #(.T(frac_res_t)) res_ch ();

  rational_arithmetic_unit #(.OPERAND_BITS(OB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source)
  );

  fraction_board board = new();

  int  sent;          // requests accepted so far
  bit  steady;        // no idling on either side while set
  int  hold_left;     // receiver long hold-off, in cycles
  bit  held_once;

  // clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // watch both channels at each rising edge; values are pre-edge
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      board.note_request(req_ch.data);
      sent++;
    end
    if (rst_ni && res_ch.valid && res_ch.ready)
      board.check_result(res_ch.data);
  end

  // receiver: random ready, one long hold-off midway through the run
  always @(posedge clk_i) begin
    if (!held_once && sent >= 700) begin
      held_once <= 1'b1;
      hold_left <= 4000;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // offer one request and wait for it to be taken, maybe after a gap
  task automatic send_request(frac_req_t rq);
    if (!steady && $urandom_range(0, 99) < 29) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_fraction(op_e op, int an, int ad, int bn, int bd);
    frac_req_t rq;
    rq.mode  = op;
    rq.a_num = an[OB-1:0];
    rq.a_den = ad[OB-1:0];
    rq.b_num = bn[OB-1:0];
    rq.b_den = bd[OB-1:0];
    send_request(rq);
  endtask

  // small or medium values half the time, so that reductions and zero cases are frequent
  function automatic logic [OB-1:0] pick_field();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 40) - 20;
      1:       v = $urandom_range(0, 2000) - 1000;
      default: v = $urandom;
    endcase
    return v[OB-1:0];
  endfunction

  initial begin
    frac_req_t rq;
    sent         = 0;
    steady       = 1'b0;
    hold_left    = 0;
    held_once    = 1'b0;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extremes and the special cases
    send_fraction(OpAdd, 1, 2, 1, 3);
    send_fraction(OpSub, 1, 2, 1, 2);            // zero result comes back as 0/1
    send_fraction(OpMul, -3, 4, 8, -9);
    send_fraction(OpDiv, 5, 6, -10, 3);
    send_fraction(OpAdd, 7, 0, 3, 0);            // zero denominators act as one
    send_fraction(OpDiv, 9, 12, 0, 5);           // division by zero
    send_fraction(OpDiv, -9, 12, 0, 0);
    send_fraction(OpMul, 0, -7, 5, 3);           // zero numerator, no negative zero
    send_fraction(OpDiv, -32768, -1, 1, 1);      // most negative over minus one
    send_fraction(OpMul, -32768, 1, -32768, 1);
    send_fraction(OpAdd, 32767, 1, 32767, 1);
    send_fraction(OpSub, -32768, 1, 32767, 1);
    send_fraction(OpAdd, 1, 32767, 1, -32768);
    send_fraction(OpDiv, 32767, -32768, -32768, 32767);
    send_fraction(OpMul, 1, 32767, 1, 32765);
    send_fraction(OpSub, -1, -1, -1, -1);
    send_fraction(OpAdd, 32767, 32767, -32768, -32768);
    send_fraction(OpDiv, 0, 0, 0, 0);
    send_fraction(OpSub, 12345, -32768, -1, 32767);
    send_fraction(OpDiv, -1, 32767, 32767, -1);

    // random requests, with a stretch of no idling in the middle
    for (int i = 0; i < 1330; i++) begin
      steady = (i >= 400 && i < 600);
      rq.mode  = op_e'($urandom_range(0, 3));
      rq.a_num = pick_field();
      rq.a_den = pick_field();
      rq.b_num = pick_field();
      rq.b_den = pick_field();
      send_request(rq);
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    // drain, then allow for the longest calculation
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
